### hdl/hgc_pkg.sv
// ----------------------------------------------------------------------------
// hgc_pkg
// Shared types and constants for the histogram gap compaction block.
// ----------------------------------------------------------------------------
package hgc_pkg;

	localparam int MAX_BINS = 4096;
	localparam int IDX_W    = $clog2(MAX_BINS);   // table address / index width
	localparam int CNT_W    = IDX_W + 1;          // counts that can reach MAX_BINS
	localparam int CNTR_W   = 32;                 // bin count field width
	localparam int GAP_MUL  = 10;                 // gap ratio

	localparam logic [CNT_W-1:0] BINS_RESET = CNT_W'(MAX_BINS);

	typedef enum logic [1:0] {
		OP_BIN     = 2'd0,
		OP_COMPACT = 2'd1,
		OP_RESTORE = 2'd2
	} op_t;

	// table write port
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [IDX_W-1:0] data;
	} wr_t;

	// per-beat result from the tracker, before the table read is merged in
	typedef struct packed {
		logic [IDX_W-1:0] mapped;
		logic             occupied;
		logic             last;
		logic             oor;
		logic             sel_fwd;
		logic             sel_inv;
		logic             flag;
		logic [IDX_W-1:0] largest;
	} res_t;

endpackage

### hdl/hgc_table_ram.sv
// ----------------------------------------------------------------------------
// hgc_table_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module hgc_table_ram #(
	parameter int ADDR_W = 12,
	parameter int DATA_W = 12
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read-before-write on a same-address collision
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

### hdl/hgc_tracker.sv
// ----------------------------------------------------------------------------
// hgc_tracker
// Bin walk state: dense index, gap and occupancy counts, compaction decision.
// Issues table writes for bins and range checks / table selects for pixels.
// ----------------------------------------------------------------------------
module hgc_tracker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       valid,
	input  hgc_pkg::op_t               op,
	input  logic                       occupied,
	input  logic [hgc_pkg::IDX_W-1:0]  pix,
	input  logic [hgc_pkg::CNT_W-1:0]  bins_cfg,
	output hgc_pkg::res_t              res,
	output hgc_pkg::wr_t               fwd_wr,
	output hgc_pkg::wr_t               inv_wr
);
	import hgc_pkg::*;

	logic [IDX_W-1:0] pos_q, pos_d;
	logic [CNT_W-1:0] next_q, next_d;
	logic             gap_open_q, gap_open_d;
	logic [IDX_W-1:0] gap_q, gap_d;
	logic [CNT_W-1:0] occ_q, occ_d;
	logic             flag_q, flag_d;
	logic [IDX_W-1:0] largest_q, largest_d;

	logic [CNT_W-1:0] nbins;
	logic             clr;
	logic             last;
	logic [CNT_W+2:0] gap_x10;

	// clamp bin count to 1..MAX_BINS
	always_comb begin
		if (bins_cfg == '0) begin
			nbins = CNT_W'(1);
		end else if (bins_cfg > CNT_W'(MAX_BINS)) begin
			nbins = CNT_W'(MAX_BINS);
		end else begin
			nbins = bins_cfg;
		end
	end

	always_comb begin
		clr  = valid && (op == OP_BIN) && (pos_q == '0);
		last = ({1'b0, pos_q} + CNT_W'(1)) >= nbins;

		pos_d      = pos_q;
		next_d     = clr ? '0 : next_q;
		gap_open_d = clr ? 1'b0 : gap_open_q;
		gap_d      = clr ? '0 : gap_q;
		occ_d      = clr ? '0 : occ_q;
		flag_d     = clr ? 1'b0 : flag_q;
		largest_d  = clr ? '0 : largest_q;
		gap_x10    = '0;

		res          = '0;
		res.mapped   = pix;
		fwd_wr.en    = 1'b0;
		fwd_wr.addr  = pos_q;
		fwd_wr.data  = next_d[IDX_W-1:0];
		inv_wr.en    = 1'b0;
		inv_wr.addr  = next_d[IDX_W-1:0];
		inv_wr.data  = pos_q;

		if (valid) begin
			case (op)
				OP_BIN: begin
					fwd_wr.en  = 1'b1;
					res.mapped = next_d[IDX_W-1:0];
					if (occupied) begin
						res.occupied = 1'b1;
						inv_wr.en    = ~next_d[CNT_W-1];
						next_d       = next_d + CNT_W'(1);
						occ_d        = occ_d + CNT_W'(1);
						if (gap_open_d) begin
							gap_d = gap_d + IDX_W'(1);
						end
						gap_open_d = 1'b0;
					end else begin
						gap_open_d = 1'b1;
					end
					if (last) begin
						res.last = 1'b1;
						// gap > occ/10  <=>  10*gap > occ
						gap_x10   = {gap_d, 3'b000} + {2'b00, gap_d, 1'b0};
						flag_d    = gap_x10 > (CNT_W+3)'(occ_d);
						largest_d = (flag_d && next_d != '0) ?
						            IDX_W'(next_d - CNT_W'(1)) : '0;
						pos_d     = '0;
					end else begin
						pos_d = pos_q + IDX_W'(1);
					end
				end
				OP_COMPACT: begin
					if ({1'b0, pix} >= nbins) begin
						res.oor = 1'b1;
					end else begin
						res.sel_fwd = flag_q;
					end
				end
				OP_RESTORE: begin
					if ({1'b0, pix} >= occ_q) begin
						res.oor = 1'b1;
					end else begin
						res.sel_inv = flag_q;
					end
				end
				default: begin
					res.oor = 1'b1;
				end
			endcase
		end

		res.flag    = flag_d;
		res.largest = largest_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			next_q     <= '0;
			gap_open_q <= 1'b0;
			gap_q      <= '0;
			occ_q      <= '0;
			flag_q     <= 1'b0;
			largest_q  <= '0;
		end else begin
			pos_q      <= pos_d;
			next_q     <= next_d;
			gap_open_q <= gap_open_d;
			gap_q      <= gap_d;
			occ_q      <= occ_d;
			flag_q     <= flag_d;
			largest_q  <= largest_d;
		end
	end

endmodule

### hdl/histogram_gap_compaction.sv
// ----------------------------------------------------------------------------
// histogram_gap_compaction
// Pipeline: the start beat passes the input register, then the result register
//   together with the table read, which drives the done strobe.
// Throughput: one beat per clock; busy never rises, the tables have one
//   write and one read port each, which is all a beat needs.
// Reset: arst_n clears the walk state, the pipeline valids and sets
//   bins_in_use to 4096; table contents stay undefined until written.
// Results cannot be stalled: each is shown for one cycle with done high.
// ----------------------------------------------------------------------------
module histogram_gap_compaction (
	input  logic                       clk,
	input  logic                       arst_n,
	// command side
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 operation,
	input  logic [hgc_pkg::CNTR_W-1:0] bin_count,
	input  logic [hgc_pkg::IDX_W-1:0]  pixel_value,
	// result side
	output logic                       done,
	output logic [hgc_pkg::IDX_W-1:0]  mapped_value,
	output logic                       bin_occupied,
	output logic                       table_done,
	output logic                       compaction_enabled,
	output logic [hgc_pkg::IDX_W-1:0]  max_index,
	output logic                       out_of_range,
	// configuration: bins_in_use
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [hgc_pkg::CNT_W-1:0]  cfg_data
);
	import hgc_pkg::*;

	// Every beat is a single pass: nothing ever holds off the command side
	// or the config channel.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	logic [CNT_W-1:0] bins_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_q <= BINS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			bins_q <= cfg_data;
		end
	end

	// Stage 1: input register. Only zero vs nonzero of the count is kept.
	logic             valid_s1;
	op_t              op_s1;
	logic             occ_s1;
	logic [IDX_W-1:0] pix_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_s1  <= op_t'(operation);
			occ_s1 <= |bin_count;
			pix_s1 <= pixel_value;
		end
	end

	// Walk state and per-beat decisions. Bins write the forward table, and the
	// inverse table for occupied bins, in this cycle; a pixel one beat later reads at the next edge, so it sees it.
	res_t res;
	wr_t  fwd_wr;
	wr_t  inv_wr;

	hgc_tracker u_tracker (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (valid_s1),
		.op       (op_s1),
		.occupied (occ_s1),
		.pix      (pix_s1),
		.bins_cfg (bins_q),
		.res      (res),
		.fwd_wr   (fwd_wr),
		.inv_wr   (inv_wr)
	);

	// Forward table: bin -> compact index. Inverse: compact index -> bin.
	logic [IDX_W-1:0] fwd_rd;
	logic [IDX_W-1:0] inv_rd;

	hgc_table_ram #(
		.ADDR_W (IDX_W),
		.DATA_W (IDX_W)
	) u_fwd_ram (
		.clk     (clk),
		.wr_en   (fwd_wr.en),
		.wr_addr (fwd_wr.addr),
		.wr_data (fwd_wr.data),
		.rd_addr (pix_s1),
		.rd_data (fwd_rd)
	);

	hgc_table_ram #(
		.ADDR_W (IDX_W),
		.DATA_W (IDX_W)
	) u_inv_ram (
		.clk     (clk),
		.wr_en   (inv_wr.en),
		.wr_addr (inv_wr.addr),
		.wr_data (inv_wr.data),
		.rd_addr (pix_s1),
		.rd_data (inv_rd)
	);

	// Stage 2: result register, aligned with the RAM read data.
	logic valid_s2;
	res_t res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			res_s2 <= res;
		end
	end

	// Table data is picked only for in-range pixels while compaction is on.
	always_comb begin
		if (res_s2.sel_fwd) begin
			mapped_value = fwd_rd;
		end else if (res_s2.sel_inv) begin
			mapped_value = inv_rd;
		end else begin
			mapped_value = res_s2.mapped;
		end
	end

	assign done               = valid_s2;
	assign bin_occupied       = res_s2.occupied;
	assign table_done         = res_s2.last;
	assign compaction_enabled = res_s2.flag;
	assign max_index          = res_s2.largest;
	assign out_of_range       = res_s2.oor;

	// ---------------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------------
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("accepted beat produced no result");

	a_max_when_off: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !compaction_enabled) |-> (max_index == '0))
		else $error("max_index nonzero with compaction off");

	a_bin_not_oor: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (table_done || bin_occupied)) |-> !out_of_range)
		else $error("bin result flagged out of range");

	a_one_table: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(res_s2.sel_fwd && res_s2.sel_inv))
		else $error("both tables selected");

	a_sel_needs_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (res_s2.sel_fwd || res_s2.sel_inv)) |-> (compaction_enabled && !out_of_range))
		else $error("table selected without compaction");

endmodule
